### rtl/hc_pkg.sv
// ----------------------------------------------------------------------------
// hc_pkg
// Shared types and constants for the histogram pair-count block.
// ----------------------------------------------------------------------------
package hc_pkg;

    // Field widths
    localparam int MODE_W = 2;
    localparam int SUM_W  = 12;
    localparam int CFG_W  = 11;
    localparam int PAIR_W = 34;
    localparam int DATA_W = 32;

    // Configuration port: one word register at byte address 0
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_MAX_WEIGHT = 1'b0;
    localparam logic [CFG_W-1:0] MAX_WEIGHT_RST = 11'd1024;

    // Saturation value of a pair count
    localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

    // Item operation codes
    localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR       = 2'd3;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;      // drop the running sum and any product in flight
        logic mul_en;   // operands on the inputs are valid this cycle
    } mac_ctrl_t;

endpackage

### rtl/hc_hist_ram.sv
// ----------------------------------------------------------------------------
// hc_hist_ram
// Single-port-write, single-port-read synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module hc_hist_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hc_mac.sv
// ----------------------------------------------------------------------------
// hc_mac
// Registered multiply followed by a saturating accumulate.
// ----------------------------------------------------------------------------
module hc_mac #(
    parameter int COUNT_WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hc_pkg::mac_ctrl_t        ctrl,
    input  logic [COUNT_WIDTH-1:0]   op_a,
    input  logic [COUNT_WIDTH-1:0]   op_b,
    output logic [hc_pkg::PAIR_W-1:0] acc,
    output logic                     busy
);
    import hc_pkg::*;

    localparam int PROD_W = 2 * COUNT_WIDTH;
    localparam int SUM_W2 = ((PROD_W > PAIR_W) ? PROD_W : PAIR_W) + 1;

    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;
    logic              prod_valid_next;
    logic [PAIR_W-1:0] acc_reg;
    logic [PAIR_W-1:0] acc_next;
    logic [SUM_W2-1:0] sum;

    // Saturate once the sum passes the largest count
    always_comb
    begin
        sum             = SUM_W2'(acc_reg) + SUM_W2'(prod_reg);
        acc_next        = acc_reg;
        prod_valid_next = ctrl.mul_en;
        if (ctrl.clr)
        begin
            acc_next        = '0;
            prod_valid_next = 1'b0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = (sum > SUM_W2'(PAIR_MAX)) ? PAIR_MAX : sum[PAIR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign acc  = acc_reg;
    assign busy = prod_valid_reg;

endmodule

### rtl/histogram_convolution.sv
// ----------------------------------------------------------------------------
// histogram_convolution
// Two weight histograms in on-chip memory; a query returns the number of
// pairs, one weight from each histogram, that add up to the queried total.
// ----------------------------------------------------------------------------
// Sequence: a load reads a count, then writes it back; a clear zeroes both memories;
//   a query walks n weights (at most max_weight), or skips the walk when out of range.
// Throughput: one item at a time; the next item is taken once the previous one is
//   done and any result of it is in the output register, even while it still waits.
// Reset: initialises control state and runs a clearing pass over both memories,
//   during which no item is taken (APB writes still are).
// ----------------------------------------------------------------------------
module histogram_convolution #(
    parameter int MAX_WEIGHT  = 1024,
    parameter int COUNT_WIDTH = 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hc_pkg::DATA_W-1:0]     pwdata,
    output logic [hc_pkg::DATA_W-1:0]     prdata,
    output logic                          pready,
    // Input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hc_pkg::MODE_W-1:0]     mode,
    input  logic [hc_pkg::SUM_W-1:0]      weight,
    // Result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hc_pkg::SUM_W-1:0]      sum_weight,
    output logic [hc_pkg::PAIR_W-1:0]     pair_count
);
    import hc_pkg::*;

    localparam int AW   = $clog2(MAX_WEIGHT);
    // Largest weight that both the register and the memory depth allow
    localparam int KCAP = (MAX_WEIGHT > 2047) ? 2047 : MAX_WEIGHT;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WEIGHT - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LOAD_WB = 3'd2;
    localparam logic [2:0] ST_QUERY   = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    // Weight w lives at memory address w - 1
    function automatic logic [AW-1:0] to_addr(input logic [SUM_W-1:0] w);
        logic [31:0] t;
        t = 32'(w) - 32'd1;
        return t[AW-1:0];
    endfunction

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [CFG_W-1:0] max_weight_reg, max_weight_next;

    // Payload
    logic [CFG_W-1:0]  idx_reg, idx_next;
    logic [CFG_W-1:0]  hi_reg, hi_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              sel_reg, sel_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic [PAIR_W-1:0] out_count_reg, out_count_next;

    // Datapath
    logic [CFG_W-1:0]       kmax;
    logic                   accept;
    logic                   load_ok;
    logic                   query_ok;
    logic [SUM_W-1:0]       lo_full;
    logic [SUM_W-1:0]       hi_full;
    logic [SUM_W-1:0]       partner;
    logic [AW-1:0]          first_raddr, second_raddr;
    logic [AW-1:0]          waddr;
    logic                   first_we, second_we;
    logic [COUNT_WIDTH-1:0] first_rdata, second_rdata;
    logic [COUNT_WIDTH-1:0] old_count, new_count, wdata;
    logic                   cfg_write;
    mac_ctrl_t              mac_ctrl;
    logic [PAIR_W-1:0]      mac_acc;
    logic                   mac_busy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[CFG_ADDR_W-1:2] == REG_MAX_WEIGHT);
    assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_MAX_WEIGHT)
                       ? DATA_W'(max_weight_reg) : '0;

    assign kmax = (max_weight_reg < CFG_W'(KCAP)) ? max_weight_reg : CFG_W'(KCAP);

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sum_weight = out_sum_reg;
    assign pair_count = out_count_reg;

    // Range checks and walk bounds for a load or query weight
    assign load_ok  = (weight != '0) && (weight <= SUM_W'(kmax));
    assign query_ok = (kmax != '0) && (weight >= SUM_W'(2))
                      && (weight <= {kmax, 1'b0});
    assign lo_full  = (weight > SUM_W'(kmax)) ? (weight - SUM_W'(kmax)) : SUM_W'(1);
    assign hi_full  = ((weight - SUM_W'(1)) < SUM_W'(kmax)) ? (weight - SUM_W'(1))
                                                          : SUM_W'(kmax);
    assign partner  = sum_reg - SUM_W'(idx_reg);

    // Read ports: the walk during a query, the load weight otherwise
    assign first_raddr  = (state_reg == ST_QUERY) ? to_addr(SUM_W'(idx_reg))
                                                  : to_addr(weight);
    assign second_raddr = (state_reg == ST_QUERY) ? to_addr(partner)
                                                  : to_addr(weight);

    // Write back a saturating increment, or zero during the clearing pass
    assign old_count = sel_reg ? second_rdata : first_rdata;
    assign new_count = (old_count == '1) ? old_count : old_count + COUNT_WIDTH'(1);
    assign first_we  = (state_reg == ST_CLEAR) || ((state_reg == ST_LOAD_WB) && !sel_reg);
    assign second_we = (state_reg == ST_CLEAR) || ((state_reg == ST_LOAD_WB) && sel_reg);
    assign waddr     = (state_reg == ST_CLEAR) ? clr_reg : addr_reg;
    assign wdata     = (state_reg == ST_CLEAR) ? '0 : new_count;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        rd_valid_next   = 1'b0;
        out_valid_next  = out_valid_reg;
        max_weight_next = max_weight_reg;
        idx_next        = idx_reg;
        hi_next         = hi_reg;
        sum_next        = sum_reg;
        sel_next        = sel_reg;
        addr_next       = addr_reg;
        out_sum_next    = out_sum_reg;
        out_count_next  = out_count_reg;
        mac_ctrl.clr    = 1'b0;
        mac_ctrl.mul_en = rd_valid_reg;

        if (cfg_write)
        begin
            max_weight_next = pwdata[CFG_W-1:0];
        end

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_LOAD_FIRST, MODE_LOAD_SECOND:
                        begin
                            sel_next  = (mode == MODE_LOAD_SECOND);
                            addr_next = to_addr(weight);
                            if (load_ok)
                            begin
                                state_next = ST_LOAD_WB;
                            end
                        end
                        MODE_QUERY:
                        begin
                            mac_ctrl.clr = 1'b1;
                            sum_next     = weight;
                            idx_next     = lo_full[CFG_W-1:0];
                            hi_next      = hi_full[CFG_W-1:0];
                            state_next   = query_ok ? ST_QUERY : ST_FINISH;
                        end
                        default:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_LOAD_WB:
            begin
                state_next = ST_IDLE;
            end
            ST_QUERY:
            begin
                rd_valid_next = 1'b1;
                idx_next      = idx_reg + CFG_W'(1);
                if (idx_reg == hi_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the pipeline drains and the output register is free
                if (!rd_valid_reg && !mac_busy && (!out_valid_reg || out_ready))
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_reg;
                    out_count_next = mac_acc;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_weight_reg <= MAX_WEIGHT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
            max_weight_reg <= max_weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hi_reg        <= hi_next;
        sum_reg       <= sum_next;
        sel_reg       <= sel_next;
        addr_reg      <= addr_next;
        out_sum_reg   <= out_sum_next;
        out_count_reg <= out_count_next;
    end

    hc_hist_ram #(
        .DEPTH (MAX_WEIGHT),
        .WIDTH (COUNT_WIDTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    hc_hist_ram #(
        .DEPTH (MAX_WEIGHT),
        .WIDTH (COUNT_WIDTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    hc_mac #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (first_rdata),
        .op_b  (second_rdata),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

`ifndef SYNTHESIS
    // A result appears only at the end of a query
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside query finish");

    // The walk stays between its bounds
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUERY) |-> ((idx_reg >= CFG_W'(1)) && (idx_reg <= hi_reg)
                                     && (idx_reg <= kmax)))
        else $error("query index out of range");

    // The partner weight of each step is a stored weight
    a_partner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QUERY) |-> ((partner >= SUM_W'(1))
                                     && (partner <= SUM_W'(kmax))))
        else $error("partner weight out of range");

    // A write back comes in the cycle after a load is accepted
    a_wb_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD_WB) |-> $past(accept && (mode != MODE_QUERY)
                                            && (mode != MODE_CLEAR)))
        else $error("write back without a load");
`endif

endmodule
